// ===== rtl/rgd_pkg.sv =====
// Shared types and constants for the run-length glyph decoder.
// Used by the decoder modules other than rgd_ram and by its checker; depends on nothing.
`default_nettype none

package rgd_pkg;

  localparam int PIXEL_COUNT_BITS_DEF = 16;
  localparam int TABLE_DEPTH_DEF      = 256;

  // Entries of the result queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int COLOUR_W = 8;

  localparam logic [1:0] CMD_STREAM = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;

  localparam logic [7:0] CTRL_MARK   = 8'h80;
  localparam logic [8:0] REPEAT_BASE = 9'h101;
  localparam logic [7:0] RUN_MAX     = 8'd128;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  stream_byte;
    logic [15:0] glyph_pixels;
    logic [7:0]  entry_index;
    logic [7:0]  entry_colour;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_colour;
    logic [7:0] run_length;
    logic       glyph_done;
    logic       clipped;
  } out_item_t;

  // A run decided by the front, waiting for its colour from the table.
  typedef struct packed {
    logic       valid;
    logic [7:0] run_length;
    logic       glyph_done;
    logic       clipped;
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/rgd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds the colour translation table of the decoder.
`default_nettype none

module rgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgd_front.sv =====
// Front end of the decoder: takes each beat, parses control bytes, counts
// pixels and issues table reads and writes. Depends on rgd_pkg.
`default_nettype none

module rgd_front import rgd_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
  parameter int TABLE_DEPTH      = TABLE_DEPTH_DEF,
  localparam int TBL_AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire in_item_t          in_item,
  output logic                   tbl_we,
  output logic [TBL_AW-1:0]      tbl_waddr,
  output logic [COLOUR_W-1:0]    tbl_wdata,
  output logic                   tbl_re,
  output logic [TBL_AW-1:0]      tbl_raddr,
  output stage_t                 stg
);

  typedef enum logic [2:0] {
    PH_CONTROL = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [7:0]                  lit_r, lit_nxt;
  logic [7:0]                  rep_r, rep_nxt;
  logic [PIXEL_COUNT_BITS-1:0] pix_r, pix_nxt;
  stage_t                      stg_r, stg_nxt;

  // Byte to table entry, reduced modulo the table depth by a constant table.
  logic [TBL_AW-1:0] mod_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod
    localparam int unsigned ModV = g % TABLE_DEPTH;
    assign mod_tab[g] = TBL_AW'(ModV);
  end

  logic [PIXEL_COUNT_BITS+15:0] load_wide;
  logic [PIXEL_COUNT_BITS+7:0]  run_wide;
  logic [PIXEL_COUNT_BITS-1:0]  run_ext;
  logic [PIXEL_COUNT_BITS-1:0]  run_eff;
  logic [PIXEL_COUNT_BITS-1:0]  pix_after;
  logic [7:0]                   run_len;
  logic [8:0]                   rep_calc;
  logic                         run_clip;
  logic                         is_stream;

  assign is_stream = in_acc && (in_item.command == CMD_STREAM);

  assign tbl_we    = in_acc && (in_item.command == CMD_WRITE);
  assign tbl_waddr = mod_tab[in_item.entry_index];
  assign tbl_wdata = in_item.entry_colour;
  assign tbl_re    = is_stream;
  assign tbl_raddr = mod_tab[in_item.stream_byte];

  assign load_wide = {{PIXEL_COUNT_BITS{1'b0}}, in_item.glyph_pixels};
  assign run_len   = (phase_r == PH_LITERAL) ? 8'd1 : rep_r;
  assign run_wide  = {{PIXEL_COUNT_BITS{1'b0}}, run_len};
  assign run_ext   = run_wide[PIXEL_COUNT_BITS-1:0];
  assign run_clip  = run_ext > pix_r;
  assign run_eff   = run_clip ? pix_r : run_ext;
  assign pix_after = pix_r - run_eff;
  assign rep_calc  = REPEAT_BASE - {1'b0, in_item.stream_byte};

  always_comb begin
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    rep_nxt   = rep_r;
    pix_nxt   = pix_r;
    stg_nxt   = '0;
    stg_nxt.run_length = run_eff[7:0];
    stg_nxt.glyph_done = (pix_after == '0);
    stg_nxt.clipped    = run_clip;
    if (in_acc) begin
      case (in_item.command)
        CMD_START: begin
          pix_nxt = load_wide[PIXEL_COUNT_BITS-1:0];
        end
        CMD_STREAM: begin
          case (phase_r)
            PH_LITERAL: begin
              if (pix_r != '0) begin
                stg_nxt.valid = 1'b1;
                pix_nxt       = pix_after;
              end
              lit_nxt = lit_r - 8'd1;
              if (lit_nxt == 8'd0) begin
                phase_nxt = PH_CONTROL;
              end
            end
            PH_REPEAT: begin
              if (pix_r != '0) begin
                stg_nxt.valid = 1'b1;
                pix_nxt       = pix_after;
              end
              rep_nxt   = 8'd0;
              phase_nxt = PH_CONTROL;
            end
            default: begin
              if (in_item.stream_byte < CTRL_MARK) begin
                lit_nxt   = in_item.stream_byte + 8'd1;
                phase_nxt = PH_LITERAL;
              end else if (in_item.stream_byte > CTRL_MARK) begin
                rep_nxt   = rep_calc[7:0];
                phase_nxt = PH_REPEAT;
              end else begin
                phase_nxt = PH_CONTROL;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CONTROL;
      lit_r   <= 8'd0;
      rep_r   <= 8'd0;
      pix_r   <= '0;
      stg_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      rep_r   <= rep_nxt;
      pix_r   <= pix_nxt;
      stg_r   <= stg_nxt;
    end
  end

  assign stg = stg_r;

endmodule

`default_nettype wire

// ===== rtl/rgd_queue.sv =====
// Short FIFO of finished runs between the front end and the output stage.
// Depends on rgd_pkg for the entry type and the depth.
`default_nettype none

module rgd_queue import rgd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire out_item_t   push_data,
  input  wire logic        pop,
  output out_item_t        pop_data,
  output logic             empty,
  output logic [QCNT_W-1:0] count
);

  out_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/rgd_back.sv =====
// Output stage: moves runs from the queue into the result register.
// Depends on rgd_pkg for the result type.
`default_nettype none

module rgd_back import rgd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  input  wire out_item_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // Refill the register whenever it is empty or its beat is taken this cycle.
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item_r <= q_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/rle_glyph_decoder.sv =====
// Top level of the run-length glyph decoder.
// Instantiates rgd_front, rgd_ram, rgd_queue and rgd_back; depends on rgd_pkg.
//
//   channel  direction  payload      handshake
//   in_      input      in_item_t    in_valid / in_stall
//   out_     output     out_item_t   out_valid / out_stall
//
// One beat is taken per cycle when the output side keeps up; once its byte is
// taken, a run passes the table read, the queue and the output register to out_.
// in_stall rises once the four-entry queue plus the run in flight would fill it.
// Reset clears the parse state, the pixel count and the queue; the colour table
// is not cleared and needs no sweep, so beats are taken right after reset.
`default_nettype none

module rle_glyph_decoder import rgd_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
  parameter int TABLE_DEPTH      = TABLE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int TBL_AW = $clog2(TABLE_DEPTH);

  logic                  in_acc;
  logic                  tbl_we;
  logic [TBL_AW-1:0]     tbl_waddr;
  logic [COLOUR_W-1:0]   tbl_wdata;
  logic                  tbl_re;
  logic [TBL_AW-1:0]     tbl_raddr;
  logic [COLOUR_W-1:0]   tbl_rdata;
  stage_t                stg;
  out_item_t             q_push_data;
  out_item_t             q_data;
  logic                  q_pop;
  logic                  q_empty;
  logic [QCNT_W-1:0]     q_count;
  logic [QCNT_W:0]       q_load;

  // The run in the table stage always enters the queue next cycle, so it
  // counts against the free space.
  assign q_load   = {1'b0, q_count} + {{QCNT_W{1'b0}}, stg.valid};
  assign in_stall = q_load >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign in_acc   = in_valid && !in_stall;

  rgd_front #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
    .TABLE_DEPTH      (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_item   (in_item),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_re    (tbl_re),
    .tbl_raddr (tbl_raddr),
    .stg       (stg)
  );

  rgd_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_comb begin
    q_push_data.pixel_colour = tbl_rdata;
    q_push_data.run_length   = stg.run_length;
    q_push_data.glyph_done   = stg.glyph_done;
    q_push_data.clipped      = stg.clipped;
  end

  rgd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stg.valid),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  rgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/rgd_checker.sv =====
// Port-level checker for the run-length glyph decoder, bound to the top level.
// Depends on rgd_pkg for the beat types.
`default_nettype none

module rgd_checker import rgd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // A result beat held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // Every run covers at least one pixel and never more than a repeat allows.
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.run_length != 8'd0) && (out_item.run_length <= RUN_MAX))
    else $error("run length out of range");

  // A clipped run uses up the rest of the glyph.
  a_clip_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.clipped |-> out_item.glyph_done)
    else $error("clipped run does not finish the glyph");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

endmodule

bind rle_glyph_decoder rgd_checker u_rgd_checker (.*);

`default_nettype wire

// ===== tb/rle_glyph_decoder_tb.sv =====
// Self-checking testbench for rle_glyph_decoder: a directed table of beats, then
// well-formed glyph streams mixed with noise, checked against a local decoder model.
// Depends on rgd_pkg and rle_glyph_decoder only.

module rle_glyph_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_BEATS  = 1725;
  localparam int CALM_TAIL     = 250;
  localparam int HOLD_AT       = 500;
  localparam int PAUSE_AT      = 1000;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic [1:0] {AWAIT_CTRL, IN_LITERAL, IN_REPEAT} parse_phase_e;

  // One row of the directed table. When typed is set, the run (or its absence)
  // is written out in the row instead of being taken from the decoder model.
  typedef struct packed {
    in_item_t  beat;
    bit        typed;
    bit        has_run;
    out_item_t run;
  } vector_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Decoder model state.
  parse_phase_e parse_phase = AWAIT_CTRL;
  logic [7:0]   literal_left = '0;
  logic [7:0]   repeat_count = '0;
  logic [15:0]  pixels_left = '0;
  logic [7:0]   colour_table [256];
  bit           entry_written [256];

  out_item_t expected_runs [$];
  vector_t   directed [$];
  out_item_t oldest_run;
  bit        last_made_run;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;
  int        beats_sent = 0;
  int        runs_checked = 0;
  int        runs_done = 0;
  int        runs_clipped = 0;
  int        errors = 0;
  int        cycle_count = 0;

  rle_glyph_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("ERROR at %0t: %s is %0h, expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Emits a run against the remaining pixel count, cutting it where it overruns.
  function automatic void emit_run(input logic [7:0] colour, input logic [7:0] len,
                                   output bit emits, output out_item_t run);
    run = '0;
    emits = (pixels_left != 0);
    if (emits) begin
      run.clipped = (len > pixels_left);
      if (run.clipped) len = pixels_left[7:0];
      pixels_left = pixels_left - len;
      run.pixel_colour = colour;
      run.run_length = len;
      run.glyph_done = (pixels_left == 0);
    end
  endfunction

  function automatic void decode_beat(input in_item_t it, output bit emits,
                                      output out_item_t run);
    logic [7:0] b;
    b = it.stream_byte;
    emits = 1'b0;
    run = '0;
    case (it.command)
      CMD_START: pixels_left = it.glyph_pixels;
      CMD_WRITE: begin
        colour_table[it.entry_index] = it.entry_colour;
        entry_written[it.entry_index] = 1'b1;
      end
      CMD_STREAM: begin
        case (parse_phase)
          IN_LITERAL: begin
            emit_run(colour_table[b], 8'd1, emits, run);
            literal_left = literal_left - 8'd1;
            if (literal_left == 0) parse_phase = AWAIT_CTRL;
          end
          IN_REPEAT: begin
            emit_run(colour_table[b], repeat_count, emits, run);
            repeat_count = '0;
            parse_phase = AWAIT_CTRL;
          end
          default: begin
            if (b < CTRL_MARK) begin
              literal_left = b + 8'd1;
              parse_phase = IN_LITERAL;
            end else if (b > CTRL_MARK) begin
              repeat_count = 8'(REPEAT_BASE - {1'b0, b});
              parse_phase = IN_REPEAT;
            end else begin
              parse_phase = AWAIT_CTRL;
            end
          end
        endcase
      end
      default: ;
    endcase
  endfunction

  // Offers one beat, holds it until taken, then records what it should produce.
  task automatic send_beat(input in_item_t it);
    out_item_t run;
    bit        emits;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    decode_beat(it, emits, run);
    if (emits) expected_runs.push_back(run);
    last_made_run = emits;
    if (it.command != CMD_UNUSED) beats_sent++;
  endtask

  function automatic in_item_t noise_beat();
    in_item_t it;
    it.command = 2'($urandom_range(0, 3));
    it.stream_byte = 8'($urandom);
    it.glyph_pixels = 16'($urandom);
    it.entry_index = 8'($urandom);
    it.entry_colour = 8'($urandom);
    return it;
  endfunction

  // A data byte is only sent once its colour entry holds a value.
  task automatic send_stream(input logic [7:0] b);
    in_item_t it;
    if (parse_phase != AWAIT_CTRL && !entry_written[b]) begin
      it = noise_beat();
      it.command = CMD_WRITE;
      it.entry_index = b;
      send_beat(it);
    end
    it = noise_beat();
    it.command = CMD_STREAM;
    it.stream_byte = b;
    send_beat(it);
  endtask

  function automatic logic [15:0] glyph_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 16'd0;
    if (pick < 10) return 16'($urandom);
    if (pick < 30) return 16'($urandom_range(65, 1000));
    return 16'($urandom_range(1, 64));
  endfunction

  function automatic logic [7:0] control_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return CTRL_MARK;
    if (pick < 40) return 8'($urandom_range(0, 7));
    if (pick < 55) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(129, 255));
  endfunction

  task automatic random_beat();
    in_item_t it;
    int       pick;
    it = noise_beat();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      if (it.command == CMD_STREAM) send_stream(it.stream_byte);
      else send_beat(it);
    end else if (pick < 9) begin
      it.command = CMD_WRITE;
      send_beat(it);
    end else if (pick < 14 || (pixels_left == 0 && pick < 50)) begin
      it.command = CMD_START;
      it.glyph_pixels = glyph_size();
      send_beat(it);
    end else if (parse_phase == AWAIT_CTRL) begin
      send_stream(control_byte());
    end else begin
      send_stream(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic vector_t vec(input logic [1:0] cmd, input logic [7:0] b,
                                  input logic [15:0] px, input logic [7:0] idx,
                                  input logic [7:0] col, input bit typed, input bit has_run,
                                  input logic [7:0] colour, input logic [7:0] len,
                                  input bit done, input bit clip);
    vector_t v;
    v.beat = '{command: cmd, stream_byte: b, glyph_pixels: px, entry_index: idx,
               entry_colour: col};
    v.typed = typed;
    v.has_run = has_run;
    v.run = '{pixel_colour: colour, run_length: len, glyph_done: done, clipped: clip};
    return v;
  endfunction

  // Result side: compare every taken run with the oldest one expected.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_runs.size() == 0) begin
        report_mismatch("run with none expected, colour", out_item.pixel_colour, 0);
      end else begin
        oldest_run = expected_runs.pop_front();
        runs_checked++;
        if (oldest_run.glyph_done) runs_done++;
        if (oldest_run.clipped) runs_clipped++;
        if (out_item.pixel_colour != oldest_run.pixel_colour)
          report_mismatch("pixel_colour", out_item.pixel_colour, oldest_run.pixel_colour);
        if (out_item.run_length != oldest_run.run_length)
          report_mismatch("run_length", out_item.run_length, oldest_run.run_length);
        if (out_item.glyph_done != oldest_run.glyph_done)
          report_mismatch("glyph_done", out_item.glyph_done, oldest_run.glyph_done);
        if (out_item.clipped != oldest_run.clipped)
          report_mismatch("clipped", out_item.clipped, oldest_run.clipped);
      end
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
      hold_req = 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d runs outstanding", cycle_count,
             expected_runs.size());
    $display("rle_glyph_decoder: mismatch");
    $finish;
  end

  initial begin
    int  next_mode_at;
    bit  held;
    bit  paused;
    next_mode_at = 100;
    held = 1'b0;
    paused = 1'b0;

    directed.push_back(vec(CMD_WRITE, 8'h00, 16'h0000, 8'h00, 8'hFF, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_WRITE, 8'h00, 16'h0000, 8'hFF, 8'h00, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_WRITE, 8'h00, 16'h0000, 8'h55, 8'hAA, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_WRITE, 8'h00, 16'h0000, 8'hAA, 8'h55, 1, 0, 0, 0, 0, 0));
    // With no glyph started, a literal byte is swallowed.
    directed.push_back(vec(CMD_STREAM, 8'h00, 16'h0000, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'hFF, 16'h0000, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_START, 8'h00, 16'hFFFF, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));
    // Longest repeat run.
    directed.push_back(vec(CMD_STREAM, 8'h81, 16'h0000, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'hFF, 16'h0000, 8'h00, 8'h00,
                           1, 1, 8'h00, 8'd128, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'h80, 16'h0000, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'h01, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'h00, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    // A new start in the middle of a literal run only reloads the count.
    directed.push_back(vec(CMD_START, 8'h00, 16'd3, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'h55, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'hFF, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'hAA, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    // A repeat run that overruns the glyph is cut and flagged.
    directed.push_back(vec(CMD_START, 8'h00, 16'd5, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'h81, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'h55, 16'h0000, 8'h00, 8'h00,
                           1, 1, 8'hAA, 8'd5, 1, 1));
    directed.push_back(vec(CMD_STREAM, 8'h81, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'h00, 16'h0000, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_START, 8'h00, 16'h0000, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'h7F, 16'h0000, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));
    directed.push_back(vec(CMD_STREAM, 8'hAA, 16'h0000, 8'h00, 8'h00, 1, 0, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      send_beat(directed[k].beat);
      if (directed[k].typed) begin
        if (last_made_run) void'(expected_runs.pop_back());
        if (directed[k].has_run) expected_runs.push_back(directed[k].run);
      end
    end

    while (beats_sent < RANDOM_BEATS + directed.size()) begin
      if (beats_sent >= next_mode_at) begin
        idle_on = ($urandom_range(0, 3) != 0);
        next_mode_at += 100;
      end
      if (beats_sent >= RANDOM_BEATS + directed.size() - CALM_TAIL) idle_on = 1'b0;
      if (!held && beats_sent >= HOLD_AT) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && beats_sent >= PAUSE_AT) begin
        in_valid <= 1'b0;
        wait_drained();
        paused = 1'b1;
      end
      random_beat();
    end
    in_valid <= 1'b0;
    wait_drained();

    $display("Sent %0d beats and checked %0d runs: %0d ended a glyph, %0d were clipped.",
             beats_sent, runs_checked, runs_done, runs_clipped);
    $display("Covered literal and repeat runs, no-op controls, restarts and full glyphs.");
    if (errors == 0) begin
      $display("rle_glyph_decoder: match");
    end else begin
      $display("rle_glyph_decoder: mismatch");
    end
    $finish;
  end

endmodule
